// ===== rtl/palist_pkg.sv =====
// Shared types and constants for the positional array list.
package palist_pkg;

    // Position and count fields carried to the cells; wide enough for the largest list.
    localparam int POS_W       = 7;
    localparam int MAX_RESULTS = 16;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } t_cell_op;

    // Broadcast to every cell each cycle.
    typedef struct packed {
        t_cell_op         op;
        logic [POS_W-1:0] pos;
    } t_cell_ctrl;

endpackage

// ===== rtl/palist_cell.sv =====
// One list cell: holds a single entry and moves it with its neighbours.
module palist_cell #(
    parameter int INDEX = 0
) (
    input  logic                      i_clk,
    input  palist_pkg::t_cell_ctrl    i_ctrl,
    input  logic signed [31:0]        i_data,
    input  logic signed [31:0]        i_left,
    input  logic signed [31:0]        i_right,
    input  logic signed [31:0]        i_head,
    output logic signed [31:0]        o_value
);
    import palist_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            CELL_INS: begin
                // new item lands here, everything above moves up one
                if (MY_POS == i_ctrl.pos) begin
                    n_value = i_data;
                end else if (MY_POS > i_ctrl.pos) begin
                    n_value = i_left;
                end
            end
            CELL_DEL: begin
                if (MY_POS >= i_ctrl.pos) begin
                    n_value = i_right;
                end
            end
            CELL_ROT: begin
                // rotate the occupied part; pos marks the top entry
                if (MY_POS == i_ctrl.pos) begin
                    n_value = i_head;
                end else if (MY_POS < i_ctrl.pos) begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== rtl/positional_array_list_core.sv =====
// Top level of the positional array list: control, fill count and the row of cells.
//
// Input channel (i_valid / o_ready) takes one item: opcode, data value and slot.
// Output channel (o_valid / i_ready) gives the result items.
// Append, insert and delete: the cells from the target position up shift in the
//   accept cycle, one result (status, zero value, zero index, last flag set) is
//   offered the next cycle.
// Read-out: the row rotates through its occupied part, cell 0 feeding the
//   output, one entry per cycle while the receiver takes them. At most 16
//   entries are given; a longer list finishes its rotation silently. An empty
//   list gives a single result with status empty.
// One item is in flight at a time: o_ready is high only while idle.
// A stalled receiver freezes the row and the offered result; nothing is lost.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending
//   result. Cell contents are not cleared; the fill count alone marks them.
// CAPACITY: number of cells, 2 to 64.
module positional_array_list_core #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_data_value,
    input  logic [3:0]         i_slot,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_item_value,
    output logic [3:0]         o_item_index,
    output logic               o_last_item
);
    import palist_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_OUT  = 3'b010,
        S_READ = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [1:0]         r_status, n_status;
    t_cell_ctrl         w_ctrl;
    logic signed [31:0] w_value [CAPACITY];

    logic [POS_W-1:0]   w_fill_pos;
    logic [POS_W-1:0]   w_top_pos;
    logic [POS_W-1:0]   w_slot_pos;
    logic [POS_W-1:0]   w_cnt_pos;
    logic               w_full;
    logic               w_accept;
    logic               w_emit;
    logic               w_last;
    logic               w_step;

    assign w_fill_pos = POS_W'(r_fill);
    assign w_top_pos  = w_fill_pos - POS_W'(1);
    assign w_slot_pos = POS_W'(i_slot);
    assign w_cnt_pos  = POS_W'(r_cnt);
    assign w_full     = (w_fill_pos == POS_W'(CAPACITY));
    assign w_accept   = i_valid && (r_state == S_IDLE);

    // read-out: entries past the result limit are rotated without being shown
    assign w_emit = (w_cnt_pos < POS_W'(MAX_RESULTS));
    assign w_last = (w_cnt_pos == w_top_pos) || (w_cnt_pos == POS_W'(MAX_RESULTS - 1));
    assign w_step = (r_state == S_READ) && (!w_emit || i_ready);

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_cnt      = r_cnt;
        n_status   = r_status;
        w_ctrl.op  = CELL_HOLD;
        w_ctrl.pos = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state  = S_OUT;
                    n_status = ST_OK;
                    case (i_opcode)
                        OP_APPEND: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctrl.op  = CELL_INS;
                                w_ctrl.pos = w_fill_pos;
                                n_fill     = r_fill + CNT_W'(1);
                            end
                        end
                        OP_INSERT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else if (w_slot_pos > POS_W'(CAPACITY - 1)) begin
                                n_status = ST_BADPOS;
                            end else begin
                                // at or past the end becomes an append
                                w_ctrl.op  = CELL_INS;
                                w_ctrl.pos = (w_slot_pos >= w_fill_pos) ? w_fill_pos
                                                                        : w_slot_pos;
                                n_fill     = r_fill + CNT_W'(1);
                            end
                        end
                        OP_DELETE: begin
                            if (w_slot_pos >= w_fill_pos) begin
                                n_status = ST_BADPOS;
                            end else begin
                                w_ctrl.op  = CELL_DEL;
                                w_ctrl.pos = w_slot_pos;
                                n_fill     = r_fill - CNT_W'(1);
                            end
                        end
                        OP_READ: begin
                            if (r_fill == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_READ;
                                n_cnt   = '0;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if (w_step) begin
                    w_ctrl.op  = CELL_ROT;
                    w_ctrl.pos = w_top_pos;
                    n_cnt      = r_cnt + CNT_W'(1);
                    // full turn done: order restored
                    if (w_cnt_pos == w_top_pos) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
        end
        r_status <= n_status;
    end

    // Row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [31:0] w_left;
        logic signed [31:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_value[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign w_right = w_value[g];
        end else begin : g_mid_r
            assign w_right = w_value[g+1];
        end
        palist_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_data  (i_data_value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_value[0]),
            .o_value (w_value[g])
        );
    end

    // Output: single status result, or the head cell during read-out
    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_valid      = 1'b0;
        o_status     = ST_OK;
        o_item_value = '0;
        o_item_index = '0;
        o_last_item  = 1'b0;
        case (r_state)
            S_OUT: begin
                o_valid     = 1'b1;
                o_status    = r_status;
                o_last_item = 1'b1;
            end
            S_READ: begin
                o_valid      = w_emit;
                o_item_value = w_value[0];
                o_item_index = w_cnt_pos[3:0];
                o_last_item  = w_last;
            end
            default: begin
                o_valid = 1'b0;
            end
        endcase
    end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the positional array list core: directed cases, random traffic.
`timescale 1ns / 100ps

module testbench;

    import palist_pkg::*;

    localparam int LIST_DEPTH  = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;

    // One result item as the output channel carries it
    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic [3:0]         index;
        logic               last;
    } t_list_result;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic               o_ready;
    logic [1:0]         i_opcode     = OP_APPEND;
    logic signed [31:0] i_data_value = '0;
    logic [3:0]         i_slot       = '0;
    logic               o_valid;
    logic               i_ready      = 1'b0;
    logic [1:0]         o_status;
    logic signed [31:0] o_item_value;
    logic [3:0]         o_item_index;
    logic               o_last_item;

    // Shadow copy of the list, kept in step with every accepted item
    logic signed [31:0] shadow_list [LIST_DEPTH];
    int                 shadow_fill;
    t_list_result       pending_results [$];

    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int rx_hold_cycles = 0;
    int cycle_count    = 0;
    int fail_count     = 0;
    int items_sent     = 0;
    int results_checked = 0;
    int full_refusals  = 0;
    int empty_reads    = 0;

    positional_array_list_core #(
        .CAPACITY(LIST_DEPTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_data_value (i_data_value),
        .i_slot       (i_slot),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_item_value (o_item_value),
        .o_item_index (o_item_index),
        .o_last_item  (o_last_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one list operation to the shadow list and queue the results it gives
    function automatic void apply_list_op(input logic [1:0] op,
                                          input logic signed [31:0] value,
                                          input logic [3:0] slot);
        t_list_result res;
        int           i;
        int           n;
        res = '{ST_OK, 32'sd0, 4'd0, 1'b1};
        case (op)
            OP_APPEND: begin
                if (shadow_fill >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_list[shadow_fill] = value;
                    shadow_fill++;
                end
            end
            OP_INSERT: begin
                // full takes precedence over a bad position
                if (shadow_fill >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else if (slot > LIST_DEPTH - 1) begin
                    res.status = ST_BADPOS;
                end else begin
                    // at or past the end this degenerates to an append
                    for (i = shadow_fill; i > slot; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[(slot >= shadow_fill) ? shadow_fill : slot] = value;
                    shadow_fill++;
                end
            end
            OP_DELETE: begin
                if (slot >= shadow_fill) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (i = slot; i + 1 < shadow_fill; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_fill--;
                end
            end
            default: begin
                if (shadow_fill == 0) begin
                    res.status = ST_EMPTY;
                    empty_reads++;
                end else begin
                    n = (shadow_fill < MAX_RESULTS) ? shadow_fill : MAX_RESULTS;
                    for (i = 0; i < n; i++)
                        pending_results.push_back('{ST_OK, shadow_list[i], i[3:0],
                                                    (i == n - 1)});
                    return;
                end
            end
        endcase
        if (res.status == ST_FULL)
            full_refusals++;
        pending_results.push_back(res);
    endfunction

    // Offer one item after a random gap and hold it until the block takes it.
    // Valid is left high on return so back-to-back items need no second assignment.
    task automatic offer_list_op(input logic [1:0] op, input logic signed [31:0] value,
                                 input logic [3:0] slot);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_data_value <= value;
        i_slot       <= slot;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        apply_list_op(op, value, slot);
        items_sent++;
    endtask

    task automatic test_empty_list();
        offer_list_op(OP_READ, 32'sd0, 4'd0);
        offer_list_op(OP_DELETE, 32'sd0, 4'd0);
        offer_list_op(OP_DELETE, -32'sd1, 4'd15);
    endtask

    task automatic test_append_extremes();
        offer_list_op(OP_APPEND, 32'sh8000_0000, 4'd0);
        offer_list_op(OP_APPEND, 32'sh7FFF_FFFF, 4'd15);
        offer_list_op(OP_APPEND, 32'sd0, 4'd0);
        offer_list_op(OP_APPEND, -32'sd1, 4'd0);
    endtask

    task automatic test_insert_positions();
        offer_list_op(OP_INSERT, 32'sd11, 4'd0);   // front
        offer_list_op(OP_INSERT, 32'sd22, 4'd2);   // middle
        offer_list_op(OP_INSERT, 32'sd33, 4'd6);   // exactly at the end
        offer_list_op(OP_INSERT, 32'sd44, 4'd15);  // well past the end
    endtask

    task automatic test_delete_positions();
        offer_list_op(OP_DELETE, 32'sd0, 4'd0);    // front
        offer_list_op(OP_DELETE, 32'sd0, 4'd6);    // last entry
        offer_list_op(OP_DELETE, 32'sd0, 4'd6);    // one past the last
    endtask

    task automatic test_full_list();
        while (shadow_fill < LIST_DEPTH)
            offer_list_op(OP_APPEND, $urandom, 4'($urandom_range(15)));
        offer_list_op(OP_APPEND, 32'sd5, 4'd0);
        offer_list_op(OP_INSERT, 32'sd6, 4'd3);
        offer_list_op(OP_READ, 32'sd0, 4'd0);
    endtask

    // Receiver goes dark for a long stretch while items keep coming
    task automatic test_backpressure();
        rx_hold_cycles = 300;
        offer_list_op(OP_READ, 32'sd0, 4'd0);
        offer_list_op(OP_DELETE, 32'sd0, 4'd1);
        offer_list_op(OP_APPEND, $urandom, 4'd0);
        offer_list_op(OP_INSERT, $urandom, 4'd0);
        offer_list_op(OP_READ, 32'sd0, 4'd0);
        offer_list_op(OP_DELETE, 32'sd0, 4'd0);
        offer_list_op(OP_READ, 32'sd0, 4'd0);
    endtask

    // Mostly well-formed traffic that swings the list between empty and full,
    // with some random opcodes and out-of-range slots mixed in
    task automatic test_random_traffic(input int count);
        logic [1:0]         op;
        logic signed [31:0] value;
        logic [3:0]         slot;
        int                 pick;
        int                 top;
        bit                 growing;
        growing = (shadow_fill < LIST_DEPTH / 2);
        repeat (count) begin
            if (shadow_fill == LIST_DEPTH)
                growing = 1'b0;
            else if (shadow_fill == 0)
                growing = 1'b1;
            else if ($urandom_range(99) < 3)
                growing = !growing;
            pick = $urandom_range(99);
            if (pick < 14)
                op = OP_READ;
            else if (pick < 20)
                op = 2'($urandom_range(3));
            else if ((pick < 84) == growing)
                op = $urandom_range(1) ? OP_APPEND : OP_INSERT;
            else
                op = OP_DELETE;

            case ($urandom_range(7))
                0:       value = 32'sh8000_0000;
                1:       value = 32'sh7FFF_FFFF;
                2:       value = -32'sd1;
                3:       value = 32'sd0;
                default: value = $urandom;
            endcase

            // slots mostly land on a legal position, sometimes anywhere
            top = (op == OP_DELETE) ? shadow_fill - 1 : shadow_fill;
            if (top > 15)
                top = 15;
            if (top < 0 || $urandom_range(9) == 0)
                slot = 4'($urandom_range(15));
            else
                slot = 4'($urandom_range(top));
            offer_list_op(op, value, slot);
        end
    endtask

    // Receiver: random ready, or a counted hold-off when one is requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_ready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Result checker: every accepted result against the oldest expectation
    initial begin
        t_list_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                results_checked++;
                if (pending_results.size() == 0) begin
                    $error("unexpected result: status %0d value %0d index %0d last %0b",
                           o_status, o_item_value, o_item_index, o_last_item);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        fail_count++;
                    end
                    if (o_item_value !== want.value) begin
                        $error("item_value: expected %0d, got %0d", want.value, o_item_value);
                        fail_count++;
                    end
                    if (o_item_index !== want.index) begin
                        $error("item_index: expected %0d, got %0d", want.index, o_item_index);
                        fail_count++;
                    end
                    if (o_last_item !== want.last) begin
                        $error("last_item: expected %0b, got %0b", want.last, o_last_item);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        shadow_fill = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender light, receiver heavy
        tx_idle_pct = 16;
        rx_idle_pct = 60;
        test_empty_list();
        test_append_extremes();
        test_insert_positions();
        test_delete_positions();
        test_full_list();
        test_random_traffic(105);

        // roles swapped
        tx_idle_pct = 60;
        rx_idle_pct = 16;
        test_backpressure();
        test_random_traffic(105);

        // flat out
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(115);

        @(posedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        $display("Sent %0d items, checked %0d results in %0d cycles",
                 items_sent, results_checked, cycle_count);
        $display("Full refusals seen %0d, empty read-outs %0d, mismatches %0d",
                 full_refusals, empty_reads, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
